@@ hdl/frct_pkg.sv @@
// Shared types and constants for the flood relay confirmation tracker.
// Used by frct_ram users and by the top level; depends on nothing.
package frct_pkg;

    // Field widths of the request and result items
    localparam int TIME_W   = 32;
    localparam int STREAM_W = 4;
    localparam int ROUTE_W  = 2;
    localparam int LEN_W    = 8;
    localparam int HWIDTH_W = 3;
    localparam int CNT_W    = 32;
    localparam int FILL_W   = 6;

    // Packed bus widths (tdata rounded up to whole bytes)
    localparam int IN_DATA_W  = 56;
    localparam int IN_USER_W  = 1;
    localparam int OUT_DATA_W = 104;
    localparam int OUT_USER_W = 2;

    // Operation codes carried in the request tuser
    localparam logic OP_TRANSMIT = 1'b0;
    localparam logic OP_SIGHTING = 1'b1;

    // Number of hash widths that have a sighting counter (widths 1..4)
    localparam int WIDTH_SLOTS = 4;
    localparam int WSLOT_W     = 2;
    localparam logic [HWIDTH_W-1:0] WIDTH_MIN_COUNTED = 3'd1;
    localparam logic [HWIDTH_W-1:0] WIDTH_MAX_COUNTED = 3'd4;
    // Smallest hash width that triggers a ring scan
    localparam logic [HWIDTH_W-1:0] WIDTH_MIN_SCAN    = 3'd2;

    // Window register reset value in ms
    localparam logic [TIME_W-1:0] WINDOW_RESET = 32'd10000;

    // One transmit record held in the ring
    typedef struct packed {
        logic [TIME_W-1:0]   rec_time;
        logic [STREAM_W-1:0] rec_stream;
        logic                confirmed;
    } record_t;

    localparam int RECORD_W = $bits(record_t);

endpackage

@@ hdl/frct_ram.sv @@
// Generic single-clock RAM: one write port, one read port, registered read data.
// Depends on nothing.
module frct_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                                  clk,
    input  logic                                  we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                      wdata,
    input  logic                                  re,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                      rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

@@ hdl/flood_relay_confirm_tracker.sv @@
// Flood relay confirmation tracker. Each request is handled alone: a transmit
// event goes from acceptance to result through latch, update and result, and
// a relay sighting of width 2 or more also runs a ring scan, which reads one
// record per cycle through the single read port of the ring RAM, newest
// first, and stops at the first unconfirmed record of the same stream. The
// result waits in an output register; a new request is taken once the
// previous result has been loaded there. The ring needs no clearing pass
// after reset: only the filled entries are ever read.
// Depends on frct_pkg and frct_ram.
module flood_relay_confirm_tracker #(
    parameter int STREAMS    = 4,
    parameter int RING_DEPTH = 32
) (
    input  logic                                clk,
    input  logic                                rst_n,
    // Configuration: confirm window in ms
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [frct_pkg::TIME_W-1:0]         cfg_data,
    // Request stream
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // [31:0] now_ms, [35:32] stream, [37:36] route_type, [45:38] frame_length,
    // [48:46] hash_bytes, [55:49] zero
    input  logic [frct_pkg::IN_DATA_W-1:0]      s_tdata,
    // [0] operation
    input  logic [frct_pkg::IN_USER_W-1:0]      s_tuser,
    // Result stream
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // [31:0] sent_count, [63:32] confirmed_count, [95:64] width_count,
    // [101:96] ring_fill, [103:102] zero
    output logic [frct_pkg::OUT_DATA_W-1:0]     m_tdata,
    // [0] tx_recorded, [1] relay_credited
    output logic [frct_pkg::OUT_USER_W-1:0]     m_tuser
);

    localparam int AW = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
    localparam int CW = $clog2(RING_DEPTH + 1);
    localparam int SW = (STREAMS > 1) ? $clog2(STREAMS) : 1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_SCAN,
        ST_FINISH
    } state_t;

    state_t state_reg, state_next;

    // Latched request
    logic                             op_reg, op_next;
    logic [frct_pkg::TIME_W-1:0]      now_reg, now_next;
    logic [frct_pkg::STREAM_W-1:0]    stream_reg, stream_next;
    logic [frct_pkg::ROUTE_W-1:0]     route_reg, route_next;
    logic [frct_pkg::LEN_W-1:0]       len_reg, len_next;
    logic [frct_pkg::HWIDTH_W-1:0]    hwidth_reg, hwidth_next;

    // Ring pointers and scan control
    logic [AW-1:0]                    head_reg, head_next;
    logic [CW-1:0]                    count_reg, count_next;
    logic [AW-1:0]                    scan_ptr_reg, scan_ptr_next;
    logic [CW-1:0]                    scan_left_reg, scan_left_next;
    logic                             rd_pend_reg, rd_pend_next;
    logic [AW-1:0]                    rd_addr_reg, rd_addr_next;

    // Counters and window
    logic [frct_pkg::CNT_W-1:0]       sends_reg [STREAMS];
    logic [frct_pkg::CNT_W-1:0]       sends_next [STREAMS];
    logic [frct_pkg::CNT_W-1:0]       confirms_reg [STREAMS];
    logic [frct_pkg::CNT_W-1:0]       confirms_next [STREAMS];
    logic [frct_pkg::CNT_W-1:0]       sightings_reg [frct_pkg::WIDTH_SLOTS];
    logic [frct_pkg::CNT_W-1:0]       sightings_next [frct_pkg::WIDTH_SLOTS];
    logic [frct_pkg::TIME_W-1:0]      window_reg, window_next;

    // Result flags and output register
    logic                             recorded_reg, recorded_next;
    logic                             credited_reg, credited_next;
    logic                             m_tvalid_reg, m_tvalid_next;
    logic [frct_pkg::OUT_DATA_W-1:0]  m_tdata_reg, m_tdata_next;
    logic [frct_pkg::OUT_USER_W-1:0]  m_tuser_reg, m_tuser_next;

    // Ring RAM ports
    logic                             ram_we;
    logic [AW-1:0]                    ram_waddr;
    frct_pkg::record_t                ram_wdata;
    logic                             ram_re;
    frct_pkg::record_t                ram_rdata;

    // Derived item conditions
    logic                             stream_ok;
    logic [SW-1:0]                    sidx;
    logic                             width_ok;
    logic [frct_pkg::WSLOT_W-1:0]     widx;
    logic                             tx_ok;
    logic [AW:0]                      tail_sum;
    logic [AW:0]                      newest_sum;
    logic [AW-1:0]                    tail_slot;
    logic [AW-1:0]                    newest_slot;
    logic [AW-1:0]                    head_inc;
    logic [frct_pkg::TIME_W-1:0]      age;
    logic                             rec_match;

    frct_ram #(
        .WIDTH (frct_pkg::RECORD_W),
        .DEPTH (RING_DEPTH)
    ) u_ring (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (scan_ptr_reg),
        .rdata (ram_rdata)
    );

    assign cfg_ready = 1'b1;
    assign s_tready  = (state_reg == ST_IDLE);
    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = m_tdata_reg;
    assign m_tuser   = m_tuser_reg;

    // Item decode and ring address arithmetic
    always_comb
    begin
        stream_ok = ({1'b0, stream_reg} < (frct_pkg::STREAM_W + 1)'(STREAMS));
        sidx      = SW'(stream_reg);
        width_ok  = (hwidth_reg inside {[frct_pkg::WIDTH_MIN_COUNTED :
                                         frct_pkg::WIDTH_MAX_COUNTED]});
        widx      = frct_pkg::WSLOT_W'(hwidth_reg - frct_pkg::WIDTH_MIN_COUNTED);
        tx_ok     = (len_reg != '0) && stream_ok && (route_reg[1] == 1'b0);

        // slot after the newest record (used while the ring is not full)
        tail_sum  = {1'b0, head_reg} + (AW + 1)'(count_reg);
        if (tail_sum >= (AW + 1)'(RING_DEPTH))
        begin
            tail_sum = tail_sum - (AW + 1)'(RING_DEPTH);
        end
        tail_slot = tail_sum[AW-1:0];

        // slot of the newest record
        newest_sum = {1'b0, head_reg} + (AW + 1)'(count_reg) - 1'b1;
        if (newest_sum >= (AW + 1)'(RING_DEPTH))
        begin
            newest_sum = newest_sum - (AW + 1)'(RING_DEPTH);
        end
        newest_slot = newest_sum[AW-1:0];

        head_inc  = (head_reg == AW'(RING_DEPTH - 1)) ? '0 : head_reg + 1'b1;

        age       = now_reg - ram_rdata.rec_time;
        rec_match = (ram_rdata.rec_stream == stream_reg) && !ram_rdata.confirmed;
    end

    // Next-state logic
    always_comb
    begin
        state_next     = state_reg;
        op_next        = op_reg;
        now_next       = now_reg;
        stream_next    = stream_reg;
        route_next     = route_reg;
        len_next       = len_reg;
        hwidth_next    = hwidth_reg;
        head_next      = head_reg;
        count_next     = count_reg;
        scan_ptr_next  = scan_ptr_reg;
        scan_left_next = scan_left_reg;
        rd_pend_next   = rd_pend_reg;
        rd_addr_next   = rd_addr_reg;
        sends_next     = sends_reg;
        confirms_next  = confirms_reg;
        sightings_next = sightings_reg;
        window_next    = window_reg;
        recorded_next  = recorded_reg;
        credited_next  = credited_reg;
        m_tvalid_next  = m_tvalid_reg;
        m_tdata_next   = m_tdata_reg;
        m_tuser_next   = m_tuser_reg;
        ram_we         = 1'b0;
        ram_waddr      = tail_slot;
        ram_wdata      = '{rec_time: now_reg, rec_stream: stream_reg, confirmed: 1'b0};
        ram_re         = 1'b0;

        if (cfg_valid)
        begin
            window_next = cfg_data;
        end

        // result taken downstream
        if (m_tready)
        begin
            m_tvalid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    op_next       = s_tuser[0];
                    now_next      = s_tdata[31:0];
                    stream_next   = s_tdata[35:32];
                    route_next    = s_tdata[37:36];
                    len_next      = s_tdata[45:38];
                    hwidth_next   = s_tdata[48:46];
                    recorded_next = 1'b0;
                    credited_next = 1'b0;
                    state_next    = ST_EXEC;
                end
            end

            ST_EXEC:
            begin
                if (op_reg == frct_pkg::OP_TRANSMIT)
                begin
                    // count the send and append a record, dropping the oldest if full
                    if (tx_ok)
                    begin
                        sends_next[sidx] = sends_reg[sidx] + 1'b1;
                        recorded_next    = 1'b1;
                        ram_we           = 1'b1;
                        if (count_reg < CW'(RING_DEPTH))
                        begin
                            ram_waddr  = tail_slot;
                            count_next = count_reg + 1'b1;
                        end
                        else
                        begin
                            ram_waddr = head_reg;
                            head_next = head_inc;
                        end
                    end
                    state_next = ST_FINISH;
                end
                else
                begin
                    if (width_ok)
                    begin
                        sightings_next[widx] = sightings_reg[widx] + 1'b1;
                    end
                    if (hwidth_reg >= frct_pkg::WIDTH_MIN_SCAN)
                    begin
                        scan_ptr_next  = newest_slot;
                        scan_left_next = count_reg;
                        rd_pend_next   = 1'b0;
                        state_next     = ST_SCAN;
                    end
                    else
                    begin
                        state_next = ST_FINISH;
                    end
                end
            end

            ST_SCAN:
            begin
                // check the record read last cycle, keep one read in flight
                if (rd_pend_reg && rec_match)
                begin
                    rd_pend_next = 1'b0;
                    if (age <= window_reg)
                    begin
                        ram_we    = 1'b1;
                        ram_waddr = rd_addr_reg;
                        ram_wdata = '{rec_time:   ram_rdata.rec_time,
                                      rec_stream: ram_rdata.rec_stream,
                                      confirmed:  1'b1};
                        credited_next = 1'b1;
                        if (stream_ok)
                        begin
                            confirms_next[sidx] = confirms_reg[sidx] + 1'b1;
                        end
                    end
                    state_next = ST_FINISH;
                end
                else if (scan_left_reg != '0)
                begin
                    ram_re         = 1'b1;
                    rd_pend_next   = 1'b1;
                    rd_addr_next   = scan_ptr_reg;
                    scan_left_next = scan_left_reg - 1'b1;
                    scan_ptr_next  = (scan_ptr_reg == '0) ? AW'(RING_DEPTH - 1)
                                                          : scan_ptr_reg - 1'b1;
                end
                else
                begin
                    rd_pend_next = 1'b0;
                    if (!rd_pend_reg)
                    begin
                        state_next = ST_FINISH;
                    end
                end
            end

            ST_FINISH:
            begin
                // load the result once the output register is free
                if (!m_tvalid_reg || m_tready)
                begin
                    m_tvalid_next       = 1'b1;
                    m_tdata_next        = '0;
                    m_tdata_next[31:0]  = stream_ok ? sends_reg[sidx] : '0;
                    m_tdata_next[63:32] = stream_ok ? confirms_reg[sidx] : '0;
                    m_tdata_next[95:64] = width_ok ? sightings_reg[widx] : '0;
                    m_tdata_next[101:96] = frct_pkg::FILL_W'(count_reg);
                    m_tuser_next        = {credited_reg, recorded_reg};
                    state_next          = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // State, counters and output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            head_reg      <= '0;
            count_reg     <= '0;
            scan_left_reg <= '0;
            rd_pend_reg   <= 1'b0;
            window_reg    <= frct_pkg::WINDOW_RESET;
            recorded_reg  <= 1'b0;
            credited_reg  <= 1'b0;
            m_tvalid_reg  <= 1'b0;
            m_tdata_reg   <= '0;
            m_tuser_reg   <= '0;
            for (int i = 0; i < STREAMS; i++)
            begin
                sends_reg[i]    <= '0;
                confirms_reg[i] <= '0;
            end
            for (int i = 0; i < frct_pkg::WIDTH_SLOTS; i++)
            begin
                sightings_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg     <= state_next;
            head_reg      <= head_next;
            count_reg     <= count_next;
            scan_left_reg <= scan_left_next;
            rd_pend_reg   <= rd_pend_next;
            window_reg    <= window_next;
            recorded_reg  <= recorded_next;
            credited_reg  <= credited_next;
            m_tvalid_reg  <= m_tvalid_next;
            m_tdata_reg   <= m_tdata_next;
            m_tuser_reg   <= m_tuser_next;
            sends_reg     <= sends_next;
            confirms_reg  <= confirms_next;
            sightings_reg <= sightings_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        op_reg       <= op_next;
        now_reg      <= now_next;
        stream_reg   <= stream_next;
        route_reg    <= route_next;
        len_reg      <= len_next;
        hwidth_reg   <= hwidth_next;
        scan_ptr_reg <= scan_ptr_next;
        rd_addr_reg  <= rd_addr_next;
    end

endmodule
